>>> rtl/pfd_pkg.sv
// Shared constants for the Playfair digraph substitution block.
package pfd_pkg;

    // Default grid geometry and stored symbol width.
    localparam int DEF_GRID_ROWS   = 5;
    localparam int DEF_GRID_COLS   = 8;
    localparam int DEF_SYMBOL_BITS = 16;

    // Fixed field widths on the stream ports.
    localparam int ACTION_BITS   = 2;
    localparam int INDEX_BITS    = 6;
    localparam int FIELD_BITS    = 16;
    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 32;

    // Field offsets inside the input tdata.
    localparam int IDX_LSB    = 0;
    localparam int ENTRY_LSB  = IDX_LSB + INDEX_BITS;
    localparam int FIRST_LSB  = ENTRY_LSB + FIELD_BITS;
    localparam int SECOND_LSB = FIRST_LSB + FIELD_BITS;

    // Action codes carried in the input tuser.
    localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_ENCRYPT = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DECRYPT = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

endpackage

>>> rtl/playfair_digraph_substitution.sv
// Top level of the Playfair digraph substitution block: grid, datapath and stream ports.
//
//  channel | direction | tuser            | tdata
//  --------+-----------+------------------+-----------------------------------------------
//  s_*     | in        | action (2)       | entry_index, entry_symbol, first, second symbol
//  m_*     | out       | status (1)       | first_out, second_out
//
// One word enters per cycle when s_tready is high; pair results end in the output register.
// Both symbols are compared against all grid entries in parallel and the two target cells
// are read in the same pass, between the input register and the output register.
// Load words write the grid as they leave the input register, so a pair right behind a
// load sees the new entry.
// Reset clears the valid flags only; the grid holds nothing useful until loaded.
// A stall on m_tready holds the output register, and s_tready drops once a pair waits on it.
module playfair_digraph_substitution #(
    parameter int GRID_ROWS   = pfd_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS   = pfd_pkg::DEF_GRID_COLS,
    parameter int SYMBOL_BITS = pfd_pkg::DEF_SYMBOL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[5:0], entry_symbol[21:6], first_symbol[37:22],
    // second_symbol[53:38], zero padding[55:54]
    input  logic [pfd_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // action[1:0]
    input  logic [pfd_pkg::ACTION_BITS-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // first_out[15:0], second_out[31:16]
    output logic [pfd_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // status[0]
    output logic [0:0]                          m_tuser
);

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int IDX_W = ($clog2(CELLS + 1) > pfd_pkg::INDEX_BITS) ?
                           $clog2(CELLS + 1) : pfd_pkg::INDEX_BITS;

    // Grid storage.
    logic [SYMBOL_BITS-1:0] grid_reg [CELLS];

    // Input register.
    logic                            s1_valid_reg;
    logic [pfd_pkg::ACTION_BITS-1:0] s1_action_reg;
    logic [pfd_pkg::INDEX_BITS-1:0]  s1_idx_reg;
    logic [SYMBOL_BITS-1:0]          s1_entry_reg;
    logic [SYMBOL_BITS-1:0]          s1_first_reg;
    logic [SYMBOL_BITS-1:0]          s1_second_reg;

    // Output stage.
    logic                            m_tvalid_reg;
    logic [pfd_pkg::FIELD_BITS-1:0]  first_out_reg;
    logic [pfd_pkg::FIELD_BITS-1:0]  second_out_reg;
    logic                            status_reg;

    logic                   found_a, found_b;
    logic [ROW_W-1:0]       row_a, row_b;
    logic [COL_W-1:0]       col_a, col_b;
    logic [SYMBOL_BITS-1:0] sel_first, sel_second;

    logic             out_free, s1_result, s1_load, s1_go, s1_free, s_take;
    logic [IDX_W-1:0] s1_idx_ext;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s1_result = (s1_action_reg == pfd_pkg::ACT_ENCRYPT) ||
                       (s1_action_reg == pfd_pkg::ACT_DECRYPT);
    assign s1_load   = s1_valid_reg && (s1_action_reg == pfd_pkg::ACT_LOAD);
    assign s1_go     = s1_valid_reg && (!s1_result || out_free);
    assign s1_free   = !s1_valid_reg || s1_go;
    assign s_take    = s_tvalid && s1_free;
    assign s_tready  = s1_free;

    assign s1_idx_ext = IDX_W'(s1_idx_reg);

    pfd_locate #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_locate_a (
        .grid  (grid_reg),
        .sym   (s1_first_reg),
        .found (found_a),
        .row   (row_a),
        .col   (col_a)
    );

    pfd_locate #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_locate_b (
        .grid  (grid_reg),
        .sym   (s1_second_reg),
        .found (found_b),
        .row   (row_b),
        .col   (col_b)
    );

    pfd_select #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_select (
        .grid       (grid_reg),
        .encrypt    (s1_action_reg == pfd_pkg::ACT_ENCRYPT),
        .row_a      (row_a),
        .col_a      (col_a),
        .row_b      (row_b),
        .col_b      (col_b),
        .first_sym  (sel_first),
        .second_sym (sel_second)
    );

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_go && s1_result)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and grid writes.
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            s1_action_reg <= s_tuser;
            s1_idx_reg    <= s_tdata[pfd_pkg::IDX_LSB +: pfd_pkg::INDEX_BITS];
            s1_entry_reg  <= s_tdata[pfd_pkg::ENTRY_LSB +: SYMBOL_BITS];
            s1_first_reg  <= s_tdata[pfd_pkg::FIRST_LSB +: SYMBOL_BITS];
            s1_second_reg <= s_tdata[pfd_pkg::SECOND_LSB +: SYMBOL_BITS];
        end

        if (s1_go && s1_result)
        begin
            if (found_a && found_b)
            begin
                first_out_reg  <= pfd_pkg::FIELD_BITS'(sel_first);
                second_out_reg <= pfd_pkg::FIELD_BITS'(sel_second);
                status_reg     <= pfd_pkg::STATUS_OK;
            end
            else
            begin
                first_out_reg  <= '0;
                second_out_reg <= '0;
                status_reg     <= pfd_pkg::STATUS_NOT_FOUND;
            end
        end

        // Out-of-range indexes match no entry and are dropped.
        for (int k = 0; k < CELLS; k++)
        begin
            if (s1_go && s1_load && s1_idx_ext == IDX_W'(k))
            begin
                grid_reg[k] <= s1_entry_reg;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {second_out_reg, first_out_reg};
    assign m_tuser[0] = status_reg;

endmodule

>>> rtl/pfd_locate.sv
// Parallel match of one symbol against every grid entry, highest position wins.
module pfd_locate #(
    parameter int GRID_ROWS   = pfd_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS   = pfd_pkg::DEF_GRID_COLS,
    parameter int SYMBOL_BITS = pfd_pkg::DEF_SYMBOL_BITS
) (
    input  logic [SYMBOL_BITS-1:0]             grid [GRID_ROWS*GRID_COLS],
    input  logic [SYMBOL_BITS-1:0]             sym,
    output logic                               found,
    output logic [$clog2(GRID_ROWS)-1:0]       row,
    output logic [$clog2(GRID_COLS)-1:0]       col
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);

    always_comb
    begin
        found = 1'b0;
        row   = '0;
        col   = '0;
        // Later hits overwrite earlier ones, so the highest position is kept.
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                if (grid[r*GRID_COLS + c] == sym)
                begin
                    found = 1'b1;
                    row   = ROW_W'(r);
                    col   = COL_W'(c);
                end
            end
        end
    end

endmodule

>>> rtl/pfd_select.sv
// Applies the column, row or rectangle rule and reads the two target cells.
module pfd_select #(
    parameter int GRID_ROWS   = pfd_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS   = pfd_pkg::DEF_GRID_COLS,
    parameter int SYMBOL_BITS = pfd_pkg::DEF_SYMBOL_BITS
) (
    input  logic [SYMBOL_BITS-1:0]         grid [GRID_ROWS*GRID_COLS],
    input  logic                           encrypt,
    input  logic [$clog2(GRID_ROWS)-1:0]   row_a,
    input  logic [$clog2(GRID_COLS)-1:0]   col_a,
    input  logic [$clog2(GRID_ROWS)-1:0]   row_b,
    input  logic [$clog2(GRID_COLS)-1:0]   col_b,
    output logic [SYMBOL_BITS-1:0]         first_sym,
    output logic [SYMBOL_BITS-1:0]         second_sym
);

    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

    logic [ROW_W-1:0] row_a_step, row_b_step, tgt_row_a, tgt_row_b;
    logic [COL_W-1:0] col_a_step, col_b_step, tgt_col_a, tgt_col_b;

    // Wrapping one-step moves; encrypt moves down or right, decrypt up or left.
    always_comb
    begin
        if (encrypt)
        begin
            row_a_step = (row_a == ROW_LAST) ? '0 : row_a + ROW_W'(1);
            row_b_step = (row_b == ROW_LAST) ? '0 : row_b + ROW_W'(1);
            col_a_step = (col_a == COL_LAST) ? '0 : col_a + COL_W'(1);
            col_b_step = (col_b == COL_LAST) ? '0 : col_b + COL_W'(1);
        end
        else
        begin
            row_a_step = (row_a == '0) ? ROW_LAST : row_a - ROW_W'(1);
            row_b_step = (row_b == '0) ? ROW_LAST : row_b - ROW_W'(1);
            col_a_step = (col_a == '0) ? COL_LAST : col_a - COL_W'(1);
            col_b_step = (col_b == '0) ? COL_LAST : col_b - COL_W'(1);
        end
    end

    // An identical pair shares its column, so it falls to the column rule.
    always_comb
    begin
        if (col_a == col_b)
        begin
            tgt_row_a = row_a_step;
            tgt_col_a = col_a;
            tgt_row_b = row_b_step;
            tgt_col_b = col_b;
        end
        else if (row_a == row_b)
        begin
            tgt_row_a = row_a;
            tgt_col_a = col_a_step;
            tgt_row_b = row_b;
            tgt_col_b = col_b_step;
        end
        else
        begin
            tgt_row_a = row_b;
            tgt_col_a = col_a;
            tgt_row_b = row_a;
            tgt_col_b = col_b;
        end
    end

    // One-hot AND-OR read of the two target cells.
    always_comb
    begin
        first_sym  = '0;
        second_sym = '0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                if (tgt_row_a == ROW_W'(r) && tgt_col_a == COL_W'(c))
                begin
                    first_sym = first_sym | grid[r*GRID_COLS + c];
                end
                if (tgt_row_b == ROW_W'(r) && tgt_col_b == COL_W'(c))
                begin
                    second_sym = second_sym | grid[r*GRID_COLS + c];
                end
            end
        end
    end

endmodule

>>> rtl/pfd_checker.sv
// Port-level checks for the Playfair digraph substitution block, bound to the top level.
module pfd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [pfd_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input logic [pfd_pkg::ACTION_BITS-1:0]   s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pfd_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic [0:0]                        m_tuser
);

    // A stalled result word keeps its valid flag and its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A not-found status always comes with zeroed symbols.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == pfd_pkg::STATUS_NOT_FOUND) |-> m_tdata == '0)
        else $error("not-found result carries nonzero symbols");

    // With the output stage empty nothing can block the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result word valid during reset");

endmodule

bind playfair_digraph_substitution pfd_checker u_pfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
